FILE: hw/rtl/qrcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrcs_pkg
// Shared widths and types for the quad/rectangle coverage sampler.
// ----------------------------------------------------------------------------
package qrcs_pkg;

  localparam int COORD_W     = 16;  // vertex and rectangle corner coordinates
  localparam int SIZE_W      = 15;  // rectangle width and height
  localparam int HIT_W       = 9;   // hit count result
  localparam int HIT_MAX     = (1 << HIT_W) - 1;
  localparam int NUM_VERT    = 4;
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 16;

  // Control that travels with each sample through the pipeline
  typedef struct packed {
    logic valid;
    logic last;   // final sample of an item
  } samp_ctl_t;

endpackage

FILE: hw/rtl/qrcs_sample_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrcs_sample_seq
// Loads one item, scales it, and issues one grid sample point per cycle while adv is high.
// ----------------------------------------------------------------------------
module qrcs_sample_seq import qrcs_pkg::*; #(
  parameter int GRID_SIDE = 20,
  parameter int PW        = 23
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] vertex_x [NUM_VERT],
  input  logic signed [COORD_W-1:0] vertex_y [NUM_VERT],
  input  logic signed [COORD_W-1:0] rect_x,
  input  logic signed [COORD_W-1:0] rect_y,
  input  logic        [SIZE_W-1:0]  rect_width,
  input  logic        [SIZE_W-1:0]  rect_height,
  output samp_ctl_t                 ctl,
  output logic signed [PW-1:0]      px,
  output logic signed [PW-1:0]      py,
  output logic signed [PW-1:0]      qx [NUM_VERT],
  output logic signed [PW-1:0]      qy [NUM_VERT]
);

  localparam int IW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(GRID_SIDE - 1);
  localparam logic signed [PW-1:0] SCALE = PW'(2 * GRID_SIDE);

  logic                    busy;
  logic [IW-1:0]           col;
  logic [IW-1:0]           row;
  logic signed [PW-1:0]    py0;
  logic [SIZE_W:0]         xstep;
  logic [SIZE_W:0]         ystep;
  logic                    last_pos;
  logic                    load;
  logic signed [PW-1:0]    sqx [NUM_VERT];
  logic signed [PW-1:0]    sqy [NUM_VERT];
  logic signed [PW-1:0]    srx;
  logic signed [PW-1:0]    sry;

  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      sqx[k] = PW'(vertex_x[k]) * SCALE;
      sqy[k] = PW'(vertex_y[k]) * SCALE;
    end
    srx = PW'(rect_x) * SCALE;
    sry = PW'(rect_y) * SCALE;
  end

  assign last_pos = (col == LAST_IDX) && (row == LAST_IDX);
  assign in_ready = adv && (!busy || last_pos);
  assign load     = in_valid && in_ready;

  assign ctl.valid = busy;
  assign ctl.last  = last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (adv) begin
      if (load) begin
        busy <= 1'b1;
      end else if (last_pos) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (load) begin
        for (int k = 0; k < NUM_VERT; k++) begin
          qx[k] <= sqx[k];
          qy[k] <= sqy[k];
        end
        col   <= '0;
        row   <= '0;
        px    <= srx + $signed(PW'(rect_width));
        py    <= sry + $signed(PW'(rect_height));
        py0   <= sry + $signed(PW'(rect_height));
        xstep <= {rect_width, 1'b0};
        ystep <= {rect_height, 1'b0};
      end else if (busy && !last_pos) begin
        // walk down a column, then step to the next one
        if (row == LAST_IDX) begin
          row <= '0;
          col <= col + 1'b1;
          py  <= py0;
          px  <= px + $signed(PW'(xstep));
        end else begin
          row <= row + 1'b1;
          py  <= py + $signed(PW'(ystep));
        end
      end
    end
  end

endmodule

FILE: hw/rtl/qrcs_point_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrcs_point_test
// Three-stage crossing-number test of one sample point against the quad.
// ----------------------------------------------------------------------------
module qrcs_point_test import qrcs_pkg::*; #(
  parameter int PW = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  samp_ctl_t            in_ctl,
  input  logic signed [PW-1:0] px,
  input  logic signed [PW-1:0] py,
  input  logic signed [PW-1:0] qx [NUM_VERT],
  input  logic signed [PW-1:0] qy [NUM_VERT],
  output samp_ctl_t            out_ctl,
  output logic                 in_quad
);

  localparam int DW = PW + 1;
  localparam int MW = 2 * DW;

  // stage 1: edge and point differences
  samp_ctl_t               ctl1;
  logic signed [DW-1:0]    dxe [NUM_VERT];
  logic signed [DW-1:0]    dyp [NUM_VERT];
  logic signed [DW-1:0]    dxp [NUM_VERT];
  logic signed [DW-1:0]    dye [NUM_VERT];
  logic [NUM_VERT-1:0]     span1;
  logic [NUM_VERT-1:0]     up1;

  // stage 2: cross-product terms
  samp_ctl_t               ctl2;
  logic signed [MW-1:0]    lhs [NUM_VERT];
  logic signed [MW-1:0]    rhs [NUM_VERT];
  logic [NUM_VERT-1:0]     span2;
  logic [NUM_VERT-1:0]     up2;

  logic [NUM_VERT-1:0]     hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      out_ctl <= '0;
    end else if (adv) begin
      ctl1    <= in_ctl;
      ctl2    <= ctl1;
      out_ctl <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NUM_VERT; e++) begin
        dxe[e]   <= DW'(qx[(e + 1) % NUM_VERT]) - DW'(qx[e]);
        dyp[e]   <= DW'(py) - DW'(qy[e]);
        dxp[e]   <= DW'(px) - DW'(qx[e]);
        dye[e]   <= DW'(qy[(e + 1) % NUM_VERT]) - DW'(qy[e]);
        span1[e] <= (qy[e] > py) != (qy[(e + 1) % NUM_VERT] > py);
        up1[e]   <= qy[(e + 1) % NUM_VERT] > qy[e];
      end
      for (int e = 0; e < NUM_VERT; e++) begin
        lhs[e] <= MW'(dxe[e]) * MW'(dyp[e]);
        rhs[e] <= MW'(dxp[e]) * MW'(dye[e]);
      end
      span2 <= span1;
      up2   <= up1;
      in_quad <= ^hit;
    end
  end

  // an edge counts when it straddles the ray and the point sits on its inner side
  always_comb begin
    for (int e = 0; e < NUM_VERT; e++) begin
      hit[e] = span2[e] && (up2[e] ? (lhs[e] > rhs[e]) : (lhs[e] < rhs[e]));
    end
  end

endmodule

FILE: hw/rtl/qrcs_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrcs_accum
// Counts inside samples per item and holds the result in the output register.
// ----------------------------------------------------------------------------
module qrcs_accum import qrcs_pkg::*; #(
  parameter int GRID_SIDE = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  samp_ctl_t        in_ctl,
  input  logic             in_quad,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [HIT_W-1:0] hit_count
);

  localparam int CNT_W = $clog2(GRID_SIDE * GRID_SIDE + 1);
  localparam int SAT_W = (CNT_W > HIT_W) ? CNT_W : HIT_W;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [SAT_W-1:0] total;

  assign cnt_next = cnt + CNT_W'(in_quad);
  assign total    = SAT_W'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv && in_ctl.valid) begin
        cnt <= in_ctl.last ? '0 : cnt_next;
      end
      // load a finished count over an empty or departing result, else drop on transfer
      if (adv && in_ctl.valid && in_ctl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ctl.valid && in_ctl.last) begin
      hit_count <= (total > SAT_W'(HIT_MAX)) ? HIT_W'(HIT_MAX) : HIT_W'(total);
    end
  end

endmodule

FILE: hw/rtl/quad_rect_coverage_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_rect_coverage_sampler
// Counts the GRID_SIDE x GRID_SIDE rectangle cell centres inside a quad.
// ----------------------------------------------------------------------------
// Each transfer on the slave side carries a quad and a rectangle; one
// transfer with the hit count comes out on the master side. A single
// pipelined point tester checks one grid sample per cycle while the
// pipeline is not held, so an item has GRID_SIDE*GRID_SIDE samples (400
// at the default grid), and the next item is taken in the cycle its
// predecessor issues its last sample. A result waiting in the output
// register stalls nothing until the next count is finished; only then
// does the whole pipeline, input side included, hold until the waiting
// result is taken.
module quad_rect_coverage_sampler import qrcs_pkg::*; #(
  parameter int GRID_SIDE = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
  // vertex3_x, vertex3_y, rect_x, rect_y, rect_width, rect_height, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit_count, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int SW = $clog2(2 * GRID_SIDE + 1);
  localparam int PW = COORD_W + SW + 1;

  logic                      adv;
  logic signed [COORD_W-1:0] vertex_x [NUM_VERT];
  logic signed [COORD_W-1:0] vertex_y [NUM_VERT];
  logic signed [COORD_W-1:0] rect_x;
  logic signed [COORD_W-1:0] rect_y;
  logic        [SIZE_W-1:0]  rect_width;
  logic        [SIZE_W-1:0]  rect_height;
  samp_ctl_t                 seq_ctl;
  samp_ctl_t                 test_ctl;
  logic signed [PW-1:0]      px;
  logic signed [PW-1:0]      py;
  logic signed [PW-1:0]      qx [NUM_VERT];
  logic signed [PW-1:0]      qy [NUM_VERT];
  logic                      in_quad;
  logic [HIT_W-1:0]          hit_count;

  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      vertex_x[k] = s_axis_tdata[2 * k * COORD_W +: COORD_W];
      vertex_y[k] = s_axis_tdata[(2 * k + 1) * COORD_W +: COORD_W];
    end
  end

  assign rect_x      = s_axis_tdata[8 * COORD_W +: COORD_W];
  assign rect_y      = s_axis_tdata[9 * COORD_W +: COORD_W];
  assign rect_width  = s_axis_tdata[10 * COORD_W +: SIZE_W];
  assign rect_height = s_axis_tdata[10 * COORD_W + SIZE_W +: SIZE_W];

  // hold the pipeline only when a finished count meets a result still waiting
  assign adv = !(m_axis_tvalid && !m_axis_tready && test_ctl.valid && test_ctl.last);

  qrcs_sample_seq #(
    .GRID_SIDE (GRID_SIDE),
    .PW        (PW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .ctl         (seq_ctl),
    .px          (px),
    .py          (py),
    .qx          (qx),
    .qy          (qy)
  );

  qrcs_point_test #(
    .PW (PW)
  ) u_test (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_ctl  (seq_ctl),
    .px      (px),
    .py      (py),
    .qx      (qx),
    .qy      (qy),
    .out_ctl (test_ctl),
    .in_quad (in_quad)
  );

  qrcs_accum #(
    .GRID_SIDE (GRID_SIDE)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_ctl    (test_ctl),
    .in_quad   (in_quad),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .hit_count (hit_count)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - HIT_W){1'b0}}, hit_count};

endmodule

FILE: hw/rtl/qrcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrcs_checker
// Port-level checks for the coverage sampler, bound to the top level.
// ----------------------------------------------------------------------------
module qrcs_checker import qrcs_pkg::*; #(
  parameter int GRID_SIDE = 20
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int HIT_LIMIT = (GRID_SIDE * GRID_SIDE > HIT_MAX) ?
                             HIT_MAX : GRID_SIDE * GRID_SIDE;

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[HIT_W-1:0] <= HIT_W'(HIT_LIMIT)))
    else $error("hit count beyond grid size");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:HIT_W] == '0))
    else $error("nonzero pad bits in result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind quad_rect_coverage_sampler qrcs_checker #(.GRID_SIDE(GRID_SIDE)) u_checker (.*);
